// File: rtl/nks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nks_pkg
// Shared types and constants for the nearest-k selector.
// ----------------------------------------------------------------------------
package nks_pkg;

    localparam int VECTOR_LENGTH = 384;
    localparam int MAX_KEEP      = 32;
    localparam int ELEMENT_BITS  = 16;
    localparam int ID_BITS       = 16;
    localparam int DIST_BITS     = 48;
    localparam int KEEP_BITS     = 6;

    localparam int IDX_BITS  = $clog2(VECTOR_LENGTH + 1);
    localparam int ADDR_BITS = $clog2(VECTOR_LENGTH);
    localparam int SLOT_BITS = $clog2(MAX_KEEP);
    localparam int CNT_BITS  = $clog2(MAX_KEEP + 1);
    localparam int SQ_BITS   = 2 * ELEMENT_BITS + 1;

    localparam logic OP_QUERY     = 1'b0;
    localparam logic OP_CANDIDATE = 1'b1;

    typedef struct packed {
        logic                           operation;
        logic signed [ELEMENT_BITS-1:0] element;
        logic [ID_BITS-1:0]             candidate_id;
        logic                           last_element;
        logic                           last_candidate;
    } in_item_t;

    typedef struct packed {
        logic [ID_BITS-1:0]   neighbor_id;
        logic [DIST_BITS-1:0] distance_squared;
        logic                 last_result;
    } out_item_t;

    // registered input stage with the matching query element
    typedef struct packed {
        logic                           valid;
        logic                           is_candidate;
        logic                           in_range;
        logic signed [ELEMENT_BITS-1:0] element;
        logic signed [ELEMENT_BITS-1:0] query;
        logic [ID_BITS-1:0]             candidate_id;
        logic                           last_element;
        logic                           last_candidate;
    } front_t;

    // finished candidate distance headed for the sorted list
    typedef struct packed {
        logic                 valid;
        logic                 last_candidate;
        logic [ID_BITS-1:0]   candidate_id;
        logic [DIST_BITS-1:0] distance;
    } ins_t;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [DIST_BITS-1:0] distance;
    } kept_entry_t;

    typedef kept_entry_t [MAX_KEEP-1:0] kept_array_t;

    // snapshot of the list handed to the output buffer
    typedef struct packed {
        logic                valid;
        logic [CNT_BITS-1:0] count;
        kept_array_t         entries;
    } load_t;

endpackage

// File: rtl/nks_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nks_front
// Input register, shared element index and query vector store.
// ----------------------------------------------------------------------------
module nks_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              adv,
    input  nks_pkg::in_item_t s_data,
    output nks_pkg::front_t   front
);

    logic signed [nks_pkg::ELEMENT_BITS-1:0] mem [nks_pkg::VECTOR_LENGTH];

    logic [nks_pkg::IDX_BITS-1:0]  idx_reg;
    logic [nks_pkg::IDX_BITS-1:0]  idx_next;
    logic [nks_pkg::ADDR_BITS-1:0] addr;
    logic                          in_range;
    logic                          is_cand;
    logic                          valid_reg;
    logic                          valid_next;
    logic                          cand_reg;
    logic                          range_reg;
    logic signed [nks_pkg::ELEMENT_BITS-1:0] elem_reg;
    logic signed [nks_pkg::ELEMENT_BITS-1:0] query_reg;
    logic [nks_pkg::ID_BITS-1:0]   id_reg;
    logic                          last_el_reg;
    logic                          last_cand_reg;

    assign in_range = (idx_reg < nks_pkg::IDX_BITS'(nks_pkg::VECTOR_LENGTH));
    assign addr     = idx_reg[nks_pkg::ADDR_BITS-1:0];
    assign is_cand  = (s_data.operation == nks_pkg::OP_CANDIDATE);

    always_comb begin
        idx_next = idx_reg;
        if (accept) begin
            if (s_data.last_element) begin
                idx_next = '0;
            end else if (in_range) begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    assign valid_next = adv ? accept : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // query writes and candidate reads both land on the accept edge
    always_ff @(posedge aclk) begin
        if (accept && in_range) begin
            if (!is_cand) begin
                mem[addr] <= s_data.element;
            end else begin
                query_reg <= mem[addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cand_reg      <= is_cand;
            range_reg     <= in_range;
            elem_reg      <= s_data.element;
            id_reg        <= s_data.candidate_id;
            last_el_reg   <= s_data.last_element;
            last_cand_reg <= s_data.last_candidate;
        end
    end

    always_comb begin
        front.valid          = valid_reg;
        front.is_candidate   = cand_reg;
        front.in_range       = range_reg;
        front.element        = elem_reg;
        front.query          = query_reg;
        front.candidate_id   = id_reg;
        front.last_element   = last_el_reg;
        front.last_candidate = last_cand_reg;
    end

endmodule

// File: rtl/nks_dist_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nks_dist_acc
// Squared difference stage followed by the saturating distance accumulator.
// ----------------------------------------------------------------------------
module nks_dist_acc (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  nks_pkg::front_t front,
    output nks_pkg::ins_t   ins
);

    localparam int PROD_BITS = 2 * (nks_pkg::ELEMENT_BITS + 1);

    logic signed [nks_pkg::ELEMENT_BITS:0] diff;
    logic signed [PROD_BITS-1:0]           prod;
    logic [nks_pkg::SQ_BITS-1:0]           sq;

    logic                          b_valid_reg;
    logic                          b_clear_reg;
    logic                          b_insert_reg;
    logic                          b_last_cand_reg;
    logic [nks_pkg::ID_BITS-1:0]   b_id_reg;
    logic [nks_pkg::SQ_BITS-1:0]   b_sq_reg;

    logic [nks_pkg::DIST_BITS-1:0] acc_reg;
    logic [nks_pkg::DIST_BITS-1:0] acc_next;
    logic [nks_pkg::DIST_BITS:0]   sum;
    logic [nks_pkg::DIST_BITS-1:0] sat;

    logic                          ins_valid_reg;
    logic                          ins_valid_next;
    logic                          ins_last_cand_reg;
    logic [nks_pkg::ID_BITS-1:0]   ins_id_reg;
    logic [nks_pkg::DIST_BITS-1:0] ins_dist_reg;

    assign diff = {front.element[nks_pkg::ELEMENT_BITS-1], front.element}
                - {front.query[nks_pkg::ELEMENT_BITS-1], front.query};
    assign prod = diff * diff;
    assign sq   = (front.is_candidate && front.in_range)
                ? prod[nks_pkg::SQ_BITS-1:0] : '0;

    assign sum = {1'b0, acc_reg} + (nks_pkg::DIST_BITS + 1)'(b_sq_reg);
    assign sat = sum[nks_pkg::DIST_BITS] ? '1 : sum[nks_pkg::DIST_BITS-1:0];

    always_comb begin
        acc_next       = acc_reg;
        ins_valid_next = ins_valid_reg;
        if (adv) begin
            ins_valid_next = b_valid_reg && b_insert_reg;
            if (b_valid_reg) begin
                acc_next = b_clear_reg ? '0 : sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            acc_reg       <= '0;
            ins_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                b_valid_reg <= front.valid;
            end
            acc_reg       <= acc_next;
            ins_valid_reg <= ins_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_clear_reg     <= front.last_element;
            b_insert_reg    <= front.is_candidate && front.last_element;
            b_last_cand_reg <= front.last_candidate;
            b_id_reg        <= front.candidate_id;
            b_sq_reg        <= sq;

            ins_last_cand_reg <= b_last_cand_reg;
            ins_id_reg        <= b_id_reg;
            ins_dist_reg      <= sat;
        end
    end

    always_comb begin
        ins.valid          = ins_valid_reg;
        ins.last_candidate = ins_last_cand_reg;
        ins.candidate_id   = ins_id_reg;
        ins.distance       = ins_dist_reg;
    end

endmodule

// File: rtl/nks_kept_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nks_kept_list
// Sorted list of the k nearest candidates with a parallel insert.
// ----------------------------------------------------------------------------
module nks_kept_list (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic                           cfg_wr_en,
    input  logic [nks_pkg::KEEP_BITS-1:0]  cfg_wr_data,
    input  nks_pkg::ins_t                  ins,
    output nks_pkg::load_t                 load
);

    logic [nks_pkg::KEEP_BITS-1:0] keep_count_reg;
    logic [nks_pkg::CNT_BITS-1:0]  k_eff;
    logic [nks_pkg::CNT_BITS-1:0]  k_new;
    logic [nks_pkg::CNT_BITS-1:0]  cnt_reg;
    logic [nks_pkg::CNT_BITS-1:0]  cnt_next;
    logic [nks_pkg::CNT_BITS-1:0]  cnt_ins;
    logic [nks_pkg::SLOT_BITS-1:0] k_slot;

    nks_pkg::kept_array_t list_reg;
    nks_pkg::kept_array_t list_ins;
    nks_pkg::kept_entry_t new_entry;

    logic [nks_pkg::MAX_KEEP-1:0] le;
    logic                         insert_en;
    logic                         insert_ok;

    function automatic logic [nks_pkg::CNT_BITS-1:0] clamp_k(
        input logic [nks_pkg::KEEP_BITS-1:0] v
    );
        logic [nks_pkg::CNT_BITS-1:0] r;
        if (v == '0) begin
            r = nks_pkg::CNT_BITS'(1);
        end else if (v > nks_pkg::KEEP_BITS'(nks_pkg::MAX_KEEP)) begin
            r = nks_pkg::CNT_BITS'(nks_pkg::MAX_KEEP);
        end else begin
            r = nks_pkg::CNT_BITS'(v);
        end
        return r;
    endfunction

    assign k_eff  = clamp_k(keep_count_reg);
    assign k_new  = clamp_k(cfg_wr_data);
    assign k_slot = nks_pkg::SLOT_BITS'(k_eff - 1'b1);

    assign new_entry.id       = ins.candidate_id;
    assign new_entry.distance = ins.distance;

    // le is a prefix of ones: kept entries at or below the new distance
    always_comb begin
        for (int i = 0; i < nks_pkg::MAX_KEEP; i++) begin
            le[i] = (nks_pkg::CNT_BITS'(i) < cnt_reg)
                 && (list_reg[i].distance <= ins.distance);
        end
    end

    always_comb begin
        list_ins[0] = le[0] ? list_reg[0] : new_entry;
        for (int i = 1; i < nks_pkg::MAX_KEEP; i++) begin
            if (le[i]) begin
                list_ins[i] = list_reg[i];
            end else if (le[i-1]) begin
                list_ins[i] = new_entry;
            end else begin
                list_ins[i] = list_reg[i-1];
            end
        end
    end

    assign insert_en = ins.valid && adv;
    // not strictly nearer than the k-th entry: dropped
    assign insert_ok = !le[k_slot];
    assign cnt_ins   = (cnt_reg < k_eff) ? cnt_reg + 1'b1 : cnt_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (cfg_wr_en) begin
            cnt_next = (cnt_reg > k_new) ? k_new : cnt_reg;
        end else if (insert_en) begin
            if (ins.last_candidate) begin
                cnt_next = '0;
            end else if (insert_ok) begin
                cnt_next = cnt_ins;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_count_reg <= nks_pkg::KEEP_BITS'(16);
            cnt_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                keep_count_reg <= cfg_wr_data;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (insert_en && insert_ok) begin
            list_reg <= list_ins;
        end
    end

    always_comb begin
        load.valid   = insert_en && ins.last_candidate;
        load.count   = insert_ok ? cnt_ins : cnt_reg;
        load.entries = insert_ok ? list_ins : list_reg;
    end

endmodule

// File: rtl/nks_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nks_emitter
// Output buffer that holds one finished run and shifts it out nearest first.
// ----------------------------------------------------------------------------
module nks_emitter (
    input  logic               aclk,
    input  logic               aresetn,
    input  nks_pkg::load_t     load,
    input  logic               m_ready,
    output logic               m_valid,
    output nks_pkg::out_item_t m_data,
    output logic               emit_free
);

    nks_pkg::kept_array_t         ent_reg;
    logic [nks_pkg::CNT_BITS-1:0] remain_reg;
    logic [nks_pkg::CNT_BITS-1:0] remain_next;
    logic                         take;

    assign m_valid   = (remain_reg != '0);
    assign emit_free = (remain_reg == '0);
    assign take      = m_valid && m_ready;

    always_comb begin
        remain_next = remain_reg;
        if (load.valid) begin
            remain_next = load.count;
        end else if (take) begin
            remain_next = remain_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg <= '0;
        end else begin
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load.valid) begin
            ent_reg <= load.entries;
        end else if (take) begin
            for (int i = 0; i < nks_pkg::MAX_KEEP - 1; i++) begin
                ent_reg[i] <= ent_reg[i+1];
            end
        end
    end

    always_comb begin
        m_data.neighbor_id      = ent_reg[0].id;
        m_data.distance_squared = ent_reg[0].distance;
        m_data.last_result      = (remain_reg == nks_pkg::CNT_BITS'(1));
    end

endmodule

// File: rtl/nearest_k_selector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_k_selector_unit
// Streaming k-nearest selector under squared Euclidean distance.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one vector element per transaction. Query elements fill the
//   query store; candidate elements accumulate a squared distance against it.
//   The transaction with last_element closes a vector; on a candidate that
//   also carries last_candidate, the kept list is emitted on the m_ channel.
//   m_ channel: one kept candidate per transaction, nearest first, ties in
//   arrival order, last_result on the final one of the run.
//   cfg_wr_en/cfg_wr_data write keep_count (k) while the block is idle.
// Throughput: one input transaction per cycle while s_ready is high, one
//   result per cycle while m_ready is high. Before m_valid rises, the
//   closing candidate passes the input register, square, accumulate, then
//   list insert into the output buffer, each of them registered.
// Stall: a finished run waits in the output buffer while m_ready is low;
//   inputs keep flowing until another run closes, which then holds the
//   pipeline (s_ready low) until the buffer has drained.
// Reset: k = 16, list empty, element index and accumulator cleared; the
//   query store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module nearest_k_selector_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  nks_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output nks_pkg::out_item_t            m_data,
    input  logic                          cfg_wr_en,
    input  logic [nks_pkg::KEEP_BITS-1:0] cfg_wr_data
);

    nks_pkg::front_t front;
    nks_pkg::ins_t   ins;
    nks_pkg::load_t  load;
    logic            emit_free;
    logic            adv;
    logic            accept;

    // hold everything while a closing candidate waits for the output buffer
    assign adv     = !(ins.valid && ins.last_candidate && !emit_free);
    assign s_ready = adv;
    assign accept  = s_valid && s_ready;

    nks_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .adv     (adv),
        .s_data  (s_data),
        .front   (front)
    );

    nks_dist_acc u_dist_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .front   (front),
        .ins     (ins)
    );

    nks_kept_list u_kept_list (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ins         (ins),
        .load        (load)
    );

    nks_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .emit_free (emit_free)
    );

endmodule
